[rtl/smm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and field widths for the square matrix multiply block.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 4;
    localparam int ORDER_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_MULT = 2'd2,
        MODE_RD_A = 2'd3
    } t_mode;

endpackage
`default_nettype wire

[rtl/smm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read during write returns the old contents; data holds when not read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/square_matrix_multiply.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Holds matrices A and B in RAM and computes A = A * B in place.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries mode, row, col and value.
// Element writes of A or B go back to back.
// A read of A gives one transfer on the output channel (o_out_valid /
// i_out_stall); the result passes through the RAM read data register and then
// the output register before o_out_valid rises, and a new item may follow the
// read at once unless the output register is held by a stall.
// A multiply holds o_in_stall high while it runs. For each row i it makes
// n*n passes of a multiply-accumulate pipeline (A and B RAM read, one 32x32
// multiplier, one adder) that fills a row buffer, then copies that buffer
// back into row i of A. The user must write the order register (i_cfg_we /
// i_cfg_data) only while the block is idle; the block does not enforce it.
// Values above MAX_ORDER act as MAX_ORDER, zero does nothing. Reset sets the
// order to one and empties the pipeline and output register; the matrix RAMs
// are not cleared and must be written before being read. While the output is
// stalled one read result can wait in RAM output data; a further item is then
// held off until the output register frees up.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
    parameter int MAX_ORDER = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [smm_pkg::ORDER_W-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [smm_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [smm_pkg::IDX_W-1:0]     i_row,
    input  wire logic [smm_pkg::IDX_W-1:0]     i_col,
    input  wire logic signed [smm_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [smm_pkg::DATA_W-1:0]  o_element
);

    import smm_pkg::*;

    localparam int IW = $clog2(MAX_ORDER);
    localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
    localparam int OW = (IW + 1 > ORDER_W) ? IW + 1 : ORDER_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_COPY
    } t_state;

    function automatic logic [AW-1:0] f_idx(input int r, input int c);
        return AW'(r * MAX_ORDER + c);
    endfunction

    t_state              r_state;
    logic [ORDER_W-1:0]  r_order;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_j;
    logic [IW-1:0]       r_k;
    logic [IW-1:0]       r_last;

    logic                r_s1_valid;
    logic                r_s1_first;
    logic                r_s1_last;
    logic [IW-1:0]       r_s1_j;
    logic                r_s2_valid;
    logic                r_s2_first;
    logic                r_s2_last;
    logic [IW-1:0]       r_s2_j;
    logic [DATA_W-1:0]   r_s2_prod;
    logic [DATA_W-1:0]   r_acc;

    logic                r_cp_valid;
    logic [AW-1:0]       r_cp_idx;
    logic                r_rd_pend;
    logic                r_rd_zero;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_element;

    t_mode               w_mode;
    logic                w_accept;
    logic                w_in_range;
    logic [AW-1:0]       w_in_idx;
    logic                w_out_take;
    logic [OW-1:0]       w_order_ext;
    logic [OW-1:0]       w_n;
    logic [IW-1:0]       w_n_last;
    logic [DATA_W-1:0]   n_prod;
    logic [DATA_W-1:0]   n_acc;

    logic                a_we;
    logic [AW-1:0]       a_waddr;
    logic [DATA_W-1:0]   a_wdata;
    logic                a_re;
    logic [AW-1:0]       a_raddr;
    logic [DATA_W-1:0]   a_rdata;
    logic                b_we;
    logic [DATA_W-1:0]   b_rdata;
    logic                p_re;
    logic [DATA_W-1:0]   p_rdata;

    assign w_mode     = t_mode'(i_mode);
    assign w_out_take = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_cp_valid || (r_rd_pend && !w_out_take);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_range = (int'(i_row) < MAX_ORDER) && (int'(i_col) < MAX_ORDER);
    assign w_in_idx   = f_idx(int'(i_row), int'(i_col));

    // order saturates at MAX_ORDER
    assign w_order_ext = OW'(r_order);
    assign w_n         = (w_order_ext > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : w_order_ext;
    assign w_n_last    = IW'(w_n - OW'(1));

    assign n_prod = a_rdata * b_rdata;
    assign n_acc  = (r_s2_first ? '0 : r_acc) + r_s2_prod;

    // A ports: copy-back owns the write port, the block is stalled meanwhile
    assign a_we    = r_cp_valid || (w_accept && w_mode == MODE_WR_A && w_in_range);
    assign a_waddr = r_cp_valid ? r_cp_idx : w_in_idx;
    assign a_wdata = r_cp_valid ? p_rdata : DATA_W'(i_value);
    assign a_re    = (r_state == S_MAC) || (w_accept && w_mode == MODE_RD_A);
    assign a_raddr = (r_state == S_MAC) ? f_idx(int'(r_i), int'(r_k)) : w_in_idx;
    assign b_we    = w_accept && w_mode == MODE_WR_B && w_in_range;
    assign p_re    = (r_state == S_COPY);

    smm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER * MAX_ORDER)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    smm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER * MAX_ORDER)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (w_in_idx),
        .i_wdata (DATA_W'(i_value)),
        .i_re    (r_state == S_MAC),
        .i_raddr (f_idx(int'(r_k), int'(r_j))),
        .o_rdata (b_rdata)
    );

    smm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER)) u_ram_row (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid && r_s2_last),
        .i_waddr (r_s2_j),
        .i_wdata (n_acc),
        .i_re    (p_re),
        .i_raddr (r_j),
        .o_rdata (p_rdata)
    );

    // control, sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= ORDER_W'(1);
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_cp_valid  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end

            // multiply-accumulate pipeline
            r_s1_valid <= (r_state == S_MAC);
            r_s1_first <= (r_k == '0);
            r_s1_last  <= (r_k == r_last);
            r_s1_j     <= r_j;
            r_s2_valid <= r_s1_valid;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_j     <= r_s1_j;
            r_s2_prod  <= n_prod;
            if (r_s2_valid) begin
                r_acc <= n_acc;
            end

            r_cp_valid <= (r_state == S_COPY);
            r_cp_idx   <= f_idx(int'(r_i), int'(r_j));

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_mode == MODE_MULT && w_n != '0) begin
                        r_state <= S_MAC;
                        r_last  <= w_n_last;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                    end
                end
                S_MAC: begin
                    if (r_k == r_last) begin
                        r_k <= '0;
                        if (r_j == r_last) begin
                            r_j     <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end else begin
                        r_k <= r_k + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_valid && !r_s2_valid) begin
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_j == r_last) begin
                        r_j <= '0;
                        if (r_i == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_MAC;
                        end
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // read result waits in RAM data until the output register frees up
            if (w_accept && w_mode == MODE_RD_A) begin
                r_rd_pend <= 1'b1;
                r_rd_zero <= !w_in_range;
            end else if (r_rd_pend && w_out_take) begin
                r_rd_pend <= 1'b0;
            end

            if (r_rd_pend && w_out_take) begin
                r_out_valid <= 1'b1;
                r_element   <= r_rd_zero ? '0 : a_rdata;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_element   = signed'(r_element);

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE || r_cp_valid) |-> !w_accept)
        else $error("item accepted while multiply or copy-back active");

    a_pend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && w_out_take) |=> o_out_valid)
        else $error("pending read result not moved to output");

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(r_s1_valid))
        else $error("accumulate stage valid without multiply stage");

    a_copy_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (!r_s1_valid && !r_s2_valid))
        else $error("row copy started before pipeline drained");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for square_matrix_multiply: a directed table followed
// by random phases at several orders, checked against a shadow copy of A and B.
// ----------------------------------------------------------------------------
module tb_top;

    import smm_pkg::*;

    localparam int MAX_ORDER   = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS   = 14;
    localparam int HOLD_READS  = 24;

    typedef struct {
        t_mode              mode;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [DATA_W-1:0]  value;
    } t_op;

    typedef struct {
        bit                 is_cfg;
        t_op                op;
        bit                 chk;
        logic [DATA_W-1:0]  want;
    } t_vec;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [ORDER_W-1:0]       i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [MODE_W-1:0]        i_mode = '0;
    logic [IDX_W-1:0]         i_row = '0;
    logic [IDX_W-1:0]         i_col = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_element;

    square_matrix_multiply #(
        .MAX_ORDER (MAX_ORDER)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_element   (o_element)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // shadow of the block state
    logic [DATA_W-1:0]  shadow_a [MAX_ORDER][MAX_ORDER];
    logic [DATA_W-1:0]  shadow_b [MAX_ORDER][MAX_ORDER];
    bit                 a_written [MAX_ORDER][MAX_ORDER];
    bit                 b_written [MAX_ORDER][MAX_ORDER];
    logic [ORDER_W-1:0] order_reg = 5'd1;

    logic [DATA_W-1:0]  element_due [$];
    t_vec               dir_tab [$];

    int  err_count = 0;
    int  n_in = 0;
    int  n_mult = 0;
    int  n_res = 0;
    int  n_cfg = 0;
    int  burst_left = 0;
    bit  last_mult = 1'b0;
    bit  hold_req = 1'b0;
    logic [DATA_W-1:0] mon_want;

    function automatic int eff_order(input logic [ORDER_W-1:0] n);
        return (n > MAX_ORDER) ? MAX_ORDER : int'(n);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vec op_row(input t_mode m, input int r, input int c,
                                    input logic [DATA_W-1:0] v, input bit chk = 1'b0,
                                    input logic [DATA_W-1:0] want = '0);
        t_vec t;
        t.is_cfg   = 1'b0;
        t.op.mode  = m;
        t.op.row   = r[IDX_W-1:0];
        t.op.col   = c[IDX_W-1:0];
        t.op.value = v;
        t.chk      = chk;
        t.want     = want;
        return t;
    endfunction

    function automatic t_vec cfg_row(input int n);
        t_vec t;
        t = op_row(MODE_WR_A, 0, 0, n);
        t.is_cfg = 1'b1;
        return t;
    endfunction

    // apply one accepted item to the shadow state, report a read result
    task automatic shadow_apply(input t_op op, output bit gives,
                                output logic [DATA_W-1:0] elem);
        int n;
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] row_buf [MAX_ORDER];
        bit in_rng;
        in_rng = (op.row < MAX_ORDER) && (op.col < MAX_ORDER);
        gives  = 1'b0;
        elem   = '0;
        case (op.mode)
            MODE_WR_A: if (in_rng) begin
                shadow_a[op.row][op.col]  = op.value;
                a_written[op.row][op.col] = 1'b1;
            end
            MODE_WR_B: if (in_rng) begin
                shadow_b[op.row][op.col]  = op.value;
                b_written[op.row][op.col] = 1'b1;
            end
            MODE_MULT: begin
                n = eff_order(order_reg);
                // each row of A is rebuilt only after its full product row is done
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        sum = '0;
                        for (int k = 0; k < n; k++)
                            sum = sum + shadow_a[i][k] * shadow_b[k][j];
                        row_buf[j] = sum;
                    end
                    for (int j = 0; j < n; j++)
                        shadow_a[i][j] = row_buf[j];
                end
            end
            default: begin
                gives = 1'b1;
                elem  = in_rng ? shadow_a[op.row][op.col] : '0;
            end
        endcase
    endtask

    task automatic drive_op(input t_op op, input bit chk = 1'b0,
                            input logic [DATA_W-1:0] want = '0);
        bit gives;
        logic [DATA_W-1:0] elem;
        i_in_valid <= 1'b1;
        i_mode     <= op.mode;
        i_row      <= op.row;
        i_col      <= op.col;
        i_value    <= op.value;
        do @(posedge i_clk); while (o_in_stall);
        shadow_apply(op, gives, elem);
        if (gives)
            element_due.push_back(chk ? want : elem);
        n_in++;
        last_mult = (op.mode == MODE_MULT);
        if (last_mult)
            n_mult++;
    endtask

    // sender bursts with random gaps
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 16);
        end
    endtask

    // wait for all reads to come back, then for a multiply still running
    task automatic drain_wait();
        int n;
        i_in_valid <= 1'b0;
        while (element_due.size() != 0) @(posedge i_clk);
        n = eff_order(order_reg);
        repeat (last_mult ? n * n * n + n * n + 3 * n + 16 : 8) @(posedge i_clk);
    endtask

    task automatic set_order(input logic [ORDER_W-1:0] n);
        drain_wait();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        order_reg = n;
        n_cfg++;
    endtask

    function automatic t_op pick_read(input int n);
        t_op op;
        op.mode  = MODE_RD_A;
        op.value = rand_word();
        if (n > 0 && $urandom_range(0, 2) != 0) begin
            op.row = IDX_W'($urandom_range(0, n - 1));
            op.col = IDX_W'($urandom_range(0, n - 1));
        end else begin
            // never read an element of A that was not written yet
            do begin
                op.row = IDX_W'($urandom_range(0, MAX_ORDER - 1));
                op.col = IDX_W'($urandom_range(0, MAX_ORDER - 1));
            end while (!a_written[op.row][op.col]);
        end
        return op;
    endfunction

    function automatic t_op pick_op(input int n);
        t_op op;
        int p;
        p = $urandom_range(0, 99);
        if (p >= 30 && p < 84)
            return pick_read(n);
        op.mode  = (p < 30) ? (($urandom_range(0, 1) == 0) ? MODE_WR_A : MODE_WR_B)
                            : MODE_MULT;
        op.value = rand_word();
        if (n > 0 && $urandom_range(0, 9) < 7) begin
            op.row = IDX_W'($urandom_range(0, n - 1));
            op.col = IDX_W'($urandom_range(0, n - 1));
        end else begin
            op.row = IDX_W'($urandom_range(0, MAX_ORDER - 1));
            op.col = IDX_W'($urandom_range(0, MAX_ORDER - 1));
        end
        return op;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (element_due.size() == 0) begin
                $error("unexpected result transfer, element 0x%08h", o_element);
                err_count++;
            end else begin
                mon_want = element_due.pop_front();
                n_res++;
                if (o_element !== mon_want) begin
                    $error("element: expected 0x%08h, actual 0x%08h", mon_want, o_element);
                    err_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold on request
    initial begin : rx_stall
        int len;
        int style;
        forever begin
            style = $urandom_range(0, 2);
            len   = $urandom_range(8, 64);
            repeat (len) begin
                @(posedge i_clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end else begin
                    case (style)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                        default: i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial begin : stim
        int unsigned phase_order [9] = '{3, 16, 0, 31, 1, 2, 5, 9, 4};
        int n;
        int n_dir;
        t_op op;

        // order is 1 out of reset
        dir_tab.push_back(op_row(MODE_WR_A, 0, 0, 32'h7fff_ffff));
        dir_tab.push_back(op_row(MODE_WR_B, 0, 0, 32'h7fff_ffff));
        dir_tab.push_back(op_row(MODE_RD_A, 0, 0, 32'hffff_ffff, 1'b1, 32'h7fff_ffff));
        dir_tab.push_back(op_row(MODE_MULT, 15, 15, 32'hffff_ffff));
        dir_tab.push_back(op_row(MODE_RD_A, 0, 0, 32'h0, 1'b1, 32'h0000_0001));
        dir_tab.push_back(op_row(MODE_WR_A, 15, 15, 32'h8000_0000));
        dir_tab.push_back(op_row(MODE_RD_A, 15, 15, 32'h0, 1'b1, 32'h8000_0000));
        dir_tab.push_back(op_row(MODE_WR_B, 15, 0, 32'h0));
        dir_tab.push_back(op_row(MODE_WR_A, 0, 0, 32'h8000_0000));
        dir_tab.push_back(op_row(MODE_WR_B, 0, 0, 32'h8000_0000));
        dir_tab.push_back(op_row(MODE_MULT, 0, 0, 32'h0));
        dir_tab.push_back(op_row(MODE_RD_A, 0, 0, 32'h0, 1'b1, 32'h0));
        dir_tab.push_back(op_row(MODE_WR_A, 0, 0, 32'hffff_fffd));
        // order zero leaves A alone
        dir_tab.push_back(cfg_row(0));
        dir_tab.push_back(op_row(MODE_MULT, 3, 5, 32'h1234_5678));
        dir_tab.push_back(op_row(MODE_RD_A, 0, 0, 32'h0, 1'b1, 32'hffff_fffd));
        dir_tab.push_back(cfg_row(2));
        dir_tab.push_back(op_row(MODE_WR_A, 0, 1, 32'hffff_ffff));
        dir_tab.push_back(op_row(MODE_WR_A, 1, 0, 32'h0000_0002));
        dir_tab.push_back(op_row(MODE_WR_A, 1, 1, 32'h0001_0000));
        dir_tab.push_back(op_row(MODE_WR_B, 0, 1, 32'h0000_0003));
        dir_tab.push_back(op_row(MODE_WR_B, 1, 0, 32'h0000_0007));
        dir_tab.push_back(op_row(MODE_WR_B, 1, 1, 32'h0001_0000));
        dir_tab.push_back(op_row(MODE_MULT, 0, 0, 32'h0));
        dir_tab.push_back(op_row(MODE_RD_A, 1, 1, 32'h0));
        dir_tab.push_back(op_row(MODE_RD_A, 0, 1, 32'h0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[x]) begin
            if (dir_tab[x].is_cfg) begin
                set_order(dir_tab[x].op.value[ORDER_W-1:0]);
            end else begin
                drive_op(dir_tab[x].op, dir_tab[x].chk, dir_tab[x].want);
                pace();
            end
        end
        n_dir = n_in;

        foreach (phase_order[ph]) begin
            set_order(phase_order[ph][ORDER_W-1:0]);
            n = eff_order(order_reg);
            // load whatever part of the used region is still unwritten
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    if (!a_written[r][c]) begin
                        op = '{MODE_WR_A, r[IDX_W-1:0], c[IDX_W-1:0], rand_word()};
                        drive_op(op);
                        pace();
                    end
                    if (!b_written[r][c]) begin
                        op = '{MODE_WR_B, r[IDX_W-1:0], c[IDX_W-1:0], rand_word()};
                        drive_op(op);
                        pace();
                    end
                end
            end
            if (ph == 5) begin
                // back-to-back reads against a held-off receiver
                hold_req = 1'b1;
                repeat (HOLD_READS) drive_op(pick_read(n));
                pace();
            end
            repeat (PHASE_OPS) begin
                drive_op(pick_op(n));
                pace();
            end
        end

        drain_wait();
        $display("run covered %0d input transfers (%0d directed, %0d multiplies)",
                 n_in, n_dir, n_mult);
        $display("%0d read results checked across %0d order writes", n_res, n_cfg);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
